// ----- hw/rtl/ffha_pkg.sv -----
package ffha_pkg;

	// Heap geometry. Alignment is four bytes, so a header slot is offset[16:2].
	localparam int OFF_W    = 17;
	localparam int SLOT_W   = 15;
	localparam int CNT_W    = 32;
	localparam logic [OFF_W-1:0] MEM_SZ  = 17'd65536;
	localparam logic [OFF_W-1:0] HDR_SZ  = 17'd12;
	localparam logic [OFF_W-1:0] MINB_SZ = 17'd12;
	localparam logic [OFF_W-1:0] END_OFF = 17'd65548;
	localparam int SLOTS = 16388;
	localparam logic [SLOT_W-1:0] END_SLOT = 15'd16387;

	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FREE  = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_REQ = 2'd1;
	localparam logic [1:0] ST_NO_FIT  = 2'd2;
	localparam logic [1:0] ST_BAD_ADR = 2'd3;

	typedef struct packed {
		logic [1:0]       kind;
		logic [OFF_W-1:0] request_bytes;
		logic [OFF_W-1:0] block_address;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [OFF_W-1:0] data_address;
		logic [OFF_W-1:0] block_bytes;
		logic [OFF_W-1:0] used_total;
		logic [OFF_W-1:0] peak_total;
		logic [CNT_W-1:0] failures;
	} rsp_t;

	// Header word without the prev link, which lives in its own memory.
	typedef struct packed {
		logic [OFF_W-1:0] next;
		logic             used;
		logic             live;
	} hdr_t;

	function automatic logic [SLOT_W-1:0] slot_of(input logic [OFF_W-1:0] off);
		return off[OFF_W-1:2];
	endfunction

endpackage

// ----- hw/rtl/first_fit_heap_allocator.sv -----
// Steps from the input beat to the result beat: a query reads the header; a free reads the
// header, its next header unless that is the end, and its previous one, and merges free
// neighbours; a null address, a malformed address or a rejected request goes straight to
// the result. Allocate reads headers along the first-fit walk, writes one more header when
// the block is split, and reads on while the lowest-free pointer moves. Reads are registered.
// Throughput: one item at a time; the next beat is taken once the result is registered.
// Reset: after arst_n releases, a clearing pass writes all 16388 header slots, one per
// cycle, during which req_stall stays high.
module first_fit_heap_allocator (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  ffha_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output ffha_pkg::rsp_t  rsp
);

	// Controller states.
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CLR    = 4'd1;
	localparam logic [3:0] S_DONE   = 4'd2;
	localparam logic [3:0] S_A_LOOK = 4'd3;
	localparam logic [3:0] S_A_EVAL = 4'd4;
	localparam logic [3:0] S_A_SPL2 = 4'd5;
	localparam logic [3:0] S_A_FIN  = 4'd6;
	localparam logic [3:0] S_W_LOOK = 4'd7;
	localparam logic [3:0] S_W_EVAL = 4'd8;
	localparam logic [3:0] S_F_CHK  = 4'd9;
	localparam logic [3:0] S_F_N    = 4'd10;
	localparam logic [3:0] S_F_P    = 4'd11;
	localparam logic [3:0] S_F_PV   = 4'd12;
	localparam logic [3:0] S_F_WH   = 4'd13;

	localparam int W1 = ffha_pkg::OFF_W + 1;

	// The header store is split in two memories so that a prev link can be
	// rewritten in the same cycle as a next/used/live word of another header.
	ffha_pkg::hdr_t              mem_nul [ffha_pkg::SLOTS];
	logic [ffha_pkg::OFF_W-1:0]  mem_prev [ffha_pkg::SLOTS];

	logic [3:0]                  state_q;
	logic [ffha_pkg::SLOT_W-1:0] clr_q;
	logic [1:0]                  kind_q;
	logic [ffha_pkg::OFF_W-1:0]  size_q;
	logic [ffha_pkg::OFF_W-1:0]  p_q;     // cursor / header offset under work
	logic [ffha_pkg::OFF_W-1:0]  h_q;     // header being freed or queried
	logic [ffha_pkg::OFF_W-1:0]  nxt_q;
	logic [ffha_pkg::OFF_W-1:0]  prv_q;
	logic [ffha_pkg::OFF_W-1:0]  tmp_q;
	logic [ffha_pkg::OFF_W-1:0]  lf_q;
	logic [ffha_pkg::OFF_W-1:0]  use_q;
	logic [ffha_pkg::OFF_W-1:0]  peak_q;
	logic [ffha_pkg::CNT_W-1:0]  fail_q;
	logic [1:0]                  status_q;
	logic [ffha_pkg::OFF_W-1:0]  data_q;
	logic [ffha_pkg::OFF_W-1:0]  bytes_q;
	logic                        rsp_valid_q;
	ffha_pkg::rsp_t              rsp_q;

	// Memory ports.
	logic [ffha_pkg::SLOT_W-1:0] rd_slot;
	ffha_pkg::hdr_t              rd_nul;
	logic [ffha_pkg::OFF_W-1:0]  rd_prev;
	logic                        nul_we;
	logic [ffha_pkg::SLOT_W-1:0] nul_wa;
	ffha_pkg::hdr_t              nul_wd;
	logic                        prev_we;
	logic [ffha_pkg::SLOT_W-1:0] prev_wa;
	logic [ffha_pkg::OFF_W-1:0]  prev_wd;

	always_ff @(posedge clk) begin
		rd_nul  <= mem_nul[rd_slot];
		rd_prev <= mem_prev[rd_slot];
		if (nul_we) begin
			mem_nul[nul_wa] <= nul_wd;
		end
		if (prev_we) begin
			mem_prev[prev_wa] <= prev_wd;
		end
	end

	// Request decode at the input beat.
	logic             accept;
	logic [W1-1:0]    rnd;
	logic [W1-1:0]    size_in;
	logic             bad_req;
	logic [ffha_pkg::OFF_W-1:0] h_in;
	logic             bad_adr_pre;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		rnd     = ({1'b0, req.request_bytes} + W1'(3)) & ~W1'(3);
		size_in = (rnd < {1'b0, ffha_pkg::MINB_SZ}) ? {1'b0, ffha_pkg::MINB_SZ} : rnd;
		bad_req = (req.request_bytes == '0) || (size_in > {1'b0, ffha_pkg::MEM_SZ});
		h_in    = req.block_address - ffha_pkg::HDR_SZ;
		// The header size is a multiple of four, so alignment shows in the address.
		bad_adr_pre = (req.block_address < ffha_pkg::HDR_SZ) ||
			(req.block_address[1:0] != 2'b00) || (h_in >= ffha_pkg::END_OFF);
	end

	// Evaluation of the header just read during the first-fit walk.
	logic [W1-1:0] base;
	logic [W1-1:0] nx;
	logic [W1-1:0] room;
	logic          fit;
	logic          split;
	logic [W1-1:0] q_off;

	always_comb begin
		base  = {1'b0, p_q} + {1'b0, ffha_pkg::HDR_SZ};
		nx    = {1'b0, rd_nul.next};
		room  = nx - base;
		fit   = !rd_nul.used && (nx >= base) && (room >= {1'b0, size_q});
		split = room >= ({1'b0, size_q} + {1'b0, ffha_pkg::HDR_SZ} +
			{1'b0, ffha_pkg::MINB_SZ});
		q_off = base + {1'b0, size_q};
	end

	// Read address and write ports, driven by the controller state.
	always_comb begin
		rd_slot = ffha_pkg::slot_of(p_q);
		nul_we  = 1'b0;
		nul_wa  = ffha_pkg::slot_of(p_q);
		nul_wd  = '0;
		prev_we = 1'b0;
		prev_wa = ffha_pkg::slot_of(p_q);
		prev_wd = '0;
		unique case (state_q)
			S_IDLE: begin
				rd_slot = ffha_pkg::slot_of(h_in);
			end
			S_CLR: begin
				nul_we  = 1'b1;
				nul_wa  = clr_q;
				prev_we = 1'b1;
				prev_wa = clr_q;
				if (clr_q == '0) begin
					nul_wd = '{next: ffha_pkg::END_OFF, used: 1'b0, live: 1'b1};
				end else if (clr_q == ffha_pkg::END_SLOT) begin
					nul_wd  = '{next: ffha_pkg::END_OFF, used: 1'b1, live: 1'b1};
					prev_wd = ffha_pkg::END_OFF;
				end
			end
			S_A_EVAL: begin
				if (fit && split) begin
					nul_we  = 1'b1;
					nul_wa  = ffha_pkg::slot_of(q_off[ffha_pkg::OFF_W-1:0]);
					nul_wd  = '{next: rd_nul.next, used: 1'b0, live: 1'b1};
					prev_we = 1'b1;
					prev_wa = ffha_pkg::slot_of(q_off[ffha_pkg::OFF_W-1:0]);
					prev_wd = p_q;
				end else if (fit) begin
					nul_we = 1'b1;
					nul_wd = '{next: rd_nul.next, used: 1'b1, live: 1'b1};
				end
			end
			S_A_SPL2: begin
				nul_we = 1'b1;
				nul_wd = '{next: nxt_q, used: 1'b1, live: 1'b1};
				if (tmp_q != ffha_pkg::END_OFF) begin
					prev_we = 1'b1;
					prev_wa = ffha_pkg::slot_of(tmp_q);
					prev_wd = nxt_q;
				end
			end
			S_F_CHK: begin
				rd_slot = ffha_pkg::slot_of(rd_nul.next);
			end
			S_F_N: begin
				if (!rd_nul.used) begin
					nul_we = 1'b1;
					nul_wa = ffha_pkg::slot_of(nxt_q);
					nul_wd = '{next: rd_nul.next, used: rd_nul.used, live: 1'b0};
					if (rd_nul.next != ffha_pkg::END_OFF) begin
						prev_we = 1'b1;
						prev_wa = ffha_pkg::slot_of(rd_nul.next);
						prev_wd = h_q;
					end
				end
			end
			S_F_P: begin
				rd_slot = ffha_pkg::slot_of(prv_q);
				if (prv_q == h_q) begin
					nul_we = 1'b1;
					nul_wa = ffha_pkg::slot_of(h_q);
					nul_wd = '{next: nxt_q, used: 1'b0, live: 1'b1};
				end
			end
			S_F_PV: begin
				nul_we = 1'b1;
				if (!rd_nul.used) begin
					nul_wa = ffha_pkg::slot_of(prv_q);
					nul_wd = '{next: nxt_q, used: rd_nul.used, live: rd_nul.live};
					if (nxt_q != ffha_pkg::END_OFF) begin
						prev_we = 1'b1;
						prev_wa = ffha_pkg::slot_of(nxt_q);
						prev_wd = prv_q;
					end
				end else begin
					nul_wa = ffha_pkg::slot_of(h_q);
					nul_wd = '{next: nxt_q, used: 1'b0, live: 1'b1};
				end
			end
			S_F_WH: begin
				// The freed header was swallowed by its free predecessor.
				nul_we = 1'b1;
				nul_wa = ffha_pkg::slot_of(h_q);
				nul_wd = '{next: nxt_q, used: 1'b0, live: 1'b0};
			end
			default: begin
			end
		endcase
	end

	// Controller.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			lf_q        <= '0;
			use_q       <= '0;
			peak_q      <= '0;
			fail_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// A new result beat is loaded when the register is empty or being taken.
			if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ffha_pkg::END_SLOT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						kind_q   <= req.kind;
						size_q   <= size_in[ffha_pkg::OFF_W-1:0];
						h_q      <= h_in;
						data_q   <= '0;
						bytes_q  <= '0;
						p_q      <= lf_q;
						priority if (req.kind == ffha_pkg::KIND_ALLOC) begin
							if (bad_req) begin
								status_q <= ffha_pkg::ST_BAD_REQ;
								state_q  <= S_DONE;
							end else begin
								status_q <= ffha_pkg::ST_OK;
								state_q  <= S_A_LOOK;
							end
						end else if (req.kind == ffha_pkg::KIND_FREE ||
							req.kind == ffha_pkg::KIND_QUERY) begin
							if (req.block_address == '0) begin
								status_q <= ffha_pkg::ST_OK;
								state_q  <= S_DONE;
							end else if (bad_adr_pre) begin
								status_q <= ffha_pkg::ST_BAD_ADR;
								state_q  <= S_DONE;
							end else begin
								status_q <= ffha_pkg::ST_OK;
								state_q  <= S_F_CHK;
							end
						end else begin
							status_q <= ffha_pkg::ST_OK;
							state_q  <= S_DONE;
						end
					end
				end
				S_A_LOOK: begin
					if (p_q > ffha_pkg::MEM_SZ - size_q) begin
						status_q <= ffha_pkg::ST_NO_FIT;
						if (fail_q != '1) begin
							fail_q <= fail_q + 1'b1;
						end
						state_q <= S_DONE;
					end else begin
						state_q <= S_A_EVAL;
					end
				end
				S_A_EVAL: begin
					if (fit && split) begin
						nxt_q   <= q_off[ffha_pkg::OFF_W-1:0];
						tmp_q   <= rd_nul.next;
						use_q   <= use_q + size_q + ffha_pkg::HDR_SZ;
						state_q <= S_A_SPL2;
					end else if (fit) begin
						nxt_q   <= rd_nul.next;
						use_q   <= use_q + (rd_nul.next - p_q);
						state_q <= S_A_FIN;
					end else begin
						p_q     <= rd_nul.next;
						state_q <= S_A_LOOK;
					end
				end
				S_A_SPL2: begin
					state_q <= S_A_FIN;
				end
				S_A_FIN: begin
					if (peak_q < use_q) begin
						peak_q <= use_q;
					end
					data_q <= p_q + ffha_pkg::HDR_SZ;
					if (p_q == lf_q) begin
						p_q     <= nxt_q;
						state_q <= S_W_LOOK;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_W_LOOK: begin
					if (p_q == ffha_pkg::END_OFF) begin
						lf_q    <= p_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_W_EVAL;
					end
				end
				S_W_EVAL: begin
					if (rd_nul.used) begin
						p_q     <= rd_nul.next;
						state_q <= S_W_LOOK;
					end else begin
						lf_q    <= p_q;
						state_q <= S_DONE;
					end
				end
				S_F_CHK: begin
					if (!rd_nul.live || !rd_nul.used) begin
						status_q <= ffha_pkg::ST_BAD_ADR;
						state_q  <= S_DONE;
					end else if (kind_q == ffha_pkg::KIND_QUERY) begin
						bytes_q <= rd_nul.next - h_q - ffha_pkg::HDR_SZ;
						state_q <= S_DONE;
					end else begin
						use_q <= use_q - (rd_nul.next - h_q);
						if (h_q < lf_q) begin
							lf_q <= h_q;
						end
						nxt_q <= rd_nul.next;
						prv_q <= rd_prev;
						if (rd_nul.next != ffha_pkg::END_OFF) begin
							state_q <= S_F_N;
						end else begin
							state_q <= S_F_P;
						end
					end
				end
				S_F_N: begin
					if (!rd_nul.used) begin
						if (lf_q == nxt_q) begin
							lf_q <= h_q;
						end
						nxt_q <= rd_nul.next;
					end
					state_q <= S_F_P;
				end
				S_F_P: begin
					state_q <= (prv_q == h_q) ? S_DONE : S_F_PV;
				end
				S_F_PV: begin
					if (!rd_nul.used) begin
						if (lf_q == h_q) begin
							lf_q <= prv_q;
						end
						state_q <= S_F_WH;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_F_WH: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The result register holds the beat until it is taken.
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q.status       <= status_q;
			rsp_q.data_address <= data_q;
			rsp_q.block_bytes  <= bytes_q;
			rsp_q.used_total   <= use_q;
			rsp_q.peak_total   <= peak_q;
			rsp_q.failures     <= fail_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The clearing pass takes no beat.
	a_clr_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> req_stall)
		else $error("input taken during clearing pass");

	// The peak never trails the bytes in use outside an allocation in flight.
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> peak_q >= use_q)
		else $error("peak below bytes in use");

	// The lowest-free pointer stays inside the heap.
	a_lf_range: assert property (@(posedge clk) disable iff (!arst_n)
		lf_q <= ffha_pkg::END_OFF)
		else $error("lowest free pointer out of range");

	// A result is only loaded while no unread result is stalled.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_stall |=> rsp_valid_q && $stable(rsp_q))
		else $error("stalled result overwritten");

endmodule
